FILE: sv/dmts_pkg.sv
package dmts_pkg;

    localparam int ID_W        = 22;
    localparam int OP_W        = 3;
    localparam int ST_W        = 3;
    localparam int PORT_TIME_W = 16;
    localparam int PH_W        = 2;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;

    // request codes
    localparam logic [OP_W-1:0] OP_REG_DM  = 3'd0;
    localparam logic [OP_W-1:0] OP_REG_RM  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_YIELD   = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP       = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_UNSCHED   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd5;

    // task phases
    localparam logic [PH_W-1:0] PH_RUN   = 2'd1;
    localparam logic [PH_W-1:0] PH_SLEEP = 2'd2;
    localparam logic [PH_W-1:0] PH_READY = 2'd3;

endpackage

FILE: sv/dmts_ram.sv
module dmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/dmts_mdu.sv
// saturating ceil(t / p) * c, one quotient bit then one multiplier bit per cycle
module dmts_mdu #(
    parameter int TW = dmts_pkg::TIME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [TW:0]   t,
    input  logic [TW-1:0] p,
    input  logic [TW-1:0] c,
    output logic          done,
    output logic [TW:0]   res
);

    localparam int NW  = TW + 1;
    localparam int AW  = 2 * TW + 1;
    localparam int CNW = $clog2(NW + 1);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_DIV  = 2'd1;
    localparam logic [1:0] M_MUL  = 2'd2;

    localparam logic [TW:0]   TSAT   = {1'b1, {TW{1'b0}}};
    localparam logic [AW-1:0] TSAT_A = AW'(TSAT);

    logic [1:0]     state_reg, state_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [TW-1:0]  rem_reg, rem_next;
    logic [NW-1:0]  quo_reg, quo_next;
    logic [TW-1:0]  p_reg, p_next;
    logic [TW-1:0]  c_reg, c_next;
    logic [AW-1:0]  acc_reg, acc_next;
    logic [AW-1:0]  mcand_reg, mcand_next;
    logic           done_reg, done_next;

    logic [TW+1:0]  num;
    logic [TW:0]    trial;
    logic           ge;

    assign num   = {1'b0, t} + {2'b00, p} - (TW+2)'(1);
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = trial >= {1'b0, p_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    p_next   = p;
                    c_next   = c;
                    rem_next = '0;
                    acc_next = '0;
                    if (p == '0)
                    begin
                        quo_next   = TSAT;
                        mcand_next = AW'(TSAT);
                        cnt_next   = CNW'(TW);
                        state_next = M_MUL;
                    end
                    else
                    begin
                        quo_next   = num[NW-1:0];
                        cnt_next   = CNW'(NW);
                        state_next = M_DIV;
                    end
                end
            end
            M_DIV:
            begin
                rem_next = ge ? TW'(trial - {1'b0, p_reg}) : trial[TW-1:0];
                quo_next = {quo_reg[NW-2:0], ge};
                cnt_next = cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    mcand_next = AW'({quo_reg[NW-2:0], ge});
                    cnt_next   = CNW'(TW);
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                if (c_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = mcand_reg << 1;
                c_next     = c_reg >> 1;
                cnt_next   = cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        p_reg     <= p_next;
        c_reg     <= c_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign done = done_reg;
    assign res  = (acc_reg > TSAT_A) ? TSAT : acc_reg[TW:0];

endmodule

FILE: sv/deadline_monotonic_task_scheduler_top.sv
// Deadline-monotonic task scheduler with response-time admission. One request beat in
// gives exactly one result beat out, and requests are handled one at a time. The task
// table (id, period, deadline, cost) and the per-task phase live in two single-port-write
// RAMs with a registered read, kept sorted by ascending deadline; the sequencer walks
// them one entry at a time, a read state followed by a state that uses the data. A
// request first scans the table and decodes it. Register then shifts the entries above
// the insert point up, writes the new entry and runs response-time analysis: for each
// task and each fixed-point iteration, every higher-priority entry costs a read, a start
// and a ceiling-divide and multiply in the shared arithmetic unit, and the number of
// iterations per task depends on how quickly its response time settles. Remove shifts
// entries down. Release of a task that is not running, and yield, do a second scan for
// dispatch plus up to two phase writes. A new request is taken while the previous result
// is still waiting to be taken at the output.
module deadline_monotonic_task_scheduler_top #(
    parameter int MAX_TASKS = dmts_pkg::MAX_TASKS_DEF,
    parameter int TIME_BITS = dmts_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dmts_pkg::OP_W-1:0]           opcode,
    input  logic [dmts_pkg::ID_W-1:0]           task_id,
    input  logic [dmts_pkg::PORT_TIME_W-1:0]    task_period,
    input  logic [dmts_pkg::PORT_TIME_W-1:0]    task_deadline,
    input  logic [dmts_pkg::PORT_TIME_W-1:0]    task_cost,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dmts_pkg::ST_W-1:0]           status,
    output logic                                running_valid,
    output logic [dmts_pkg::ID_W-1:0]           running_id,
    output logic                                switched,
    output logic                                preempt_valid,
    output logic [dmts_pkg::ID_W-1:0]           preempt_id
);

    localparam int TW   = TIME_BITS;
    localparam int IDW  = dmts_pkg::ID_W;
    localparam int PHW  = dmts_pkg::PH_W;
    localparam int EW   = IDW + 3 * TW;
    localparam int IW   = $clog2(MAX_TASKS);
    localparam int CW   = $clog2(MAX_TASKS + 1);

    localparam logic [TW:0]   TSAT  = {1'b1, {TW{1'b0}}};
    localparam logic [TW+1:0] TSAT2 = {2'b01, {TW{1'b0}}};

    // sequencer states
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SCAN_RD = 5'd1;
    localparam logic [4:0] S_SCAN_EV = 5'd2;
    localparam logic [4:0] S_DECODE  = 5'd3;
    localparam logic [4:0] S_INS_RD  = 5'd4;
    localparam logic [4:0] S_INS_MV  = 5'd5;
    localparam logic [4:0] S_INS_WR  = 5'd6;
    localparam logic [4:0] S_REM_RD  = 5'd7;
    localparam logic [4:0] S_REM_MV  = 5'd8;
    localparam logic [4:0] S_RTA_I   = 5'd9;
    localparam logic [4:0] S_RTA_I2  = 5'd10;
    localparam logic [4:0] S_RTA_IT  = 5'd11;
    localparam logic [4:0] S_RTA_J   = 5'd12;
    localparam logic [4:0] S_RTA_J2  = 5'd13;
    localparam logic [4:0] S_RTA_MW  = 5'd14;
    localparam logic [4:0] S_RTA_CHK = 5'd15;
    localparam logic [4:0] S_DISP    = 5'd16;
    localparam logic [4:0] S_DISP2   = 5'd17;
    localparam logic [4:0] S_OUT     = 5'd18;

    logic [4:0]     state_reg, state_next;

    // latched request
    logic [dmts_pkg::OP_W-1:0] op_reg, op_next;
    logic [IDW-1:0]  rid_reg, rid_next;
    logic [TW-1:0]   rper_reg, rper_next;
    logic [TW-1:0]   rdl_reg, rdl_next;
    logic [TW-1:0]   rcost_reg, rcost_next;

    // table bookkeeping
    logic [CW-1:0]   count_reg, count_next;
    logic            run_valid_reg, run_valid_next;
    logic [IW-1:0]   run_slot_reg, run_slot_next;
    logic [IDW-1:0]  run_id_reg, run_id_next;
    logic [TW-1:0]   run_dl_reg, run_dl_next;

    // scan results
    logic            scan_disp_reg, scan_disp_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            found_reg, found_next;
    logic [CW-1:0]   fpos_reg, fpos_next;
    logic            at_set_reg, at_set_next;
    logic [CW-1:0]   at_reg, at_next;
    logic            best_v_reg, best_v_next;
    logic [IW-1:0]   best_reg, best_next;
    logic [TW-1:0]   best_dl_reg, best_dl_next;
    logic [IDW-1:0]  best_id_reg, best_id_next;

    // shifting
    logic [CW-1:0]   sh_reg, sh_next;
    logic [CW-1:0]   rem_pos_reg, rem_pos_next;

    // response-time analysis
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic [TW:0]     base_reg, base_next;
    logic [TW:0]     t_reg, t_next;
    logic [TW:0]     inter_reg, inter_next;
    logic [TW-1:0]   c_reg, c_next;
    logic [TW-1:0]   d_reg, d_next;

    // per-request result
    logic [dmts_pkg::ST_W-1:0] st_reg, st_next;
    logic            sw_reg, sw_next;
    logic            pv_reg, pv_next;
    logic [IDW-1:0]  pid_reg, pid_next;

    // output register
    logic            ov_reg, ov_next;
    logic [dmts_pkg::ST_W-1:0] o_st_reg, o_st_next;
    logic            o_rv_reg, o_rv_next;
    logic [IDW-1:0]  o_rid_reg, o_rid_next;
    logic            o_sw_reg, o_sw_next;
    logic            o_pv_reg, o_pv_next;
    logic [IDW-1:0]  o_pid_reg, o_pid_next;

    // memories
    logic            tbl_we;
    logic [IW-1:0]   tbl_waddr;
    logic [EW-1:0]   tbl_wdata;
    logic [EW-1:0]   tbl_q;
    logic            ph_we;
    logic [IW-1:0]   ph_waddr;
    logic [PHW-1:0]  ph_wdata;
    logic [PHW-1:0]  ph_q;
    logic [IW-1:0]   raddr;

    logic [IDW-1:0]  q_id;
    logic [TW-1:0]   q_per;
    logic [TW-1:0]   q_dl;
    logic [TW-1:0]   q_cost;

    logic [CW-1:0]   sh_dn;
    logic [CW-1:0]   sh_up;
    logic [TW+1:0]   sum_ic;
    logic [TW+1:0]   sum_bc;
    logic [TW+1:0]   sum_bq;
    logic [TW+1:0]   sum_ir;

    logic            mdu_start;
    logic            mdu_done;
    logic [TW:0]     mdu_res;

    assign q_id   = tbl_q[EW-1 -: IDW];
    assign q_per  = tbl_q[3*TW-1 -: TW];
    assign q_dl   = tbl_q[2*TW-1 -: TW];
    assign q_cost = tbl_q[TW-1:0];

    assign sh_dn  = sh_reg - CW'(1);
    assign sh_up  = sh_reg + CW'(1);
    assign sum_ic = {1'b0, inter_reg} + {2'b00, c_reg};
    assign sum_bc = {1'b0, base_reg} + {2'b00, c_reg};
    assign sum_bq = {1'b0, base_reg} + {2'b00, q_cost};
    assign sum_ir = {1'b0, inter_reg} + {1'b0, mdu_res};

    assign in_ready = (state_reg == S_IDLE);

    // one read address serves both memories
    always_comb
    begin
        case (state_reg)
            S_SCAN_RD: raddr = idx_reg[IW-1:0];
            S_INS_RD:  raddr = sh_dn[IW-1:0];
            S_REM_RD:  raddr = sh_up[IW-1:0];
            S_RTA_I:   raddr = i_reg[IW-1:0];
            S_RTA_J:   raddr = j_reg[IW-1:0];
            default:   raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        rid_next       = rid_reg;
        rper_next      = rper_reg;
        rdl_next       = rdl_reg;
        rcost_next     = rcost_reg;
        count_next     = count_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        run_id_next    = run_id_reg;
        run_dl_next    = run_dl_reg;
        scan_disp_next = scan_disp_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        fpos_next      = fpos_reg;
        at_set_next    = at_set_reg;
        at_next        = at_reg;
        best_v_next    = best_v_reg;
        best_next      = best_reg;
        best_dl_next   = best_dl_reg;
        best_id_next   = best_id_reg;
        sh_next        = sh_reg;
        rem_pos_next   = rem_pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        base_next      = base_reg;
        t_next         = t_reg;
        inter_next     = inter_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        st_next        = st_reg;
        sw_next        = sw_reg;
        pv_next        = pv_reg;
        pid_next       = pid_reg;
        ov_next        = ov_reg;
        o_st_next      = o_st_reg;
        o_rv_next      = o_rv_reg;
        o_rid_next     = o_rid_reg;
        o_sw_next      = o_sw_reg;
        o_pv_next      = o_pv_reg;
        o_pid_next     = o_pid_reg;

        tbl_we    = 1'b0;
        tbl_waddr = '0;
        tbl_wdata = tbl_q;
        ph_we     = 1'b0;
        ph_waddr  = '0;
        ph_wdata  = ph_q;
        mdu_start = 1'b0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = opcode;
                    rid_next       = task_id;
                    rper_next      = TW'(task_period);
                    rdl_next       = TW'(task_deadline);
                    rcost_next     = TW'(task_cost);
                    st_next        = dmts_pkg::ST_OK;
                    sw_next        = 1'b0;
                    pv_next        = 1'b0;
                    pid_next       = '0;
                    scan_disp_next = 1'b0;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    at_set_next    = 1'b0;
                    at_next        = count_reg;
                    state_next     = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = scan_disp_reg ? S_DISP : S_DECODE;
                end
                else
                begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                if (scan_disp_reg)
                begin
                    // later entries win deadline ties
                    if (ph_q == dmts_pkg::PH_READY && (!best_v_reg || q_dl <= best_dl_reg))
                    begin
                        best_v_next  = 1'b1;
                        best_next    = idx_reg[IW-1:0];
                        best_dl_next = q_dl;
                        best_id_next = q_id;
                    end
                end
                else
                begin
                    if (!found_reg && q_id == rid_reg)
                    begin
                        found_next = 1'b1;
                        fpos_next  = idx_reg;
                    end
                    if (!at_set_reg && q_dl >= rdl_reg)
                    begin
                        at_set_next = 1'b1;
                        at_next     = idx_reg;
                    end
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_SCAN_RD;
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                case (op_reg)
                    dmts_pkg::OP_REG_DM, dmts_pkg::OP_REG_RM:
                    begin
                        if ((op_reg == dmts_pkg::OP_REG_RM && rper_reg != rdl_reg)
                            || rper_reg == '0)
                        begin
                            st_next = dmts_pkg::ST_INVALID;
                        end
                        else if (found_reg)
                        begin
                            st_next = dmts_pkg::ST_DUP;
                        end
                        else if (count_reg == CW'(MAX_TASKS))
                        begin
                            st_next = dmts_pkg::ST_FULL;
                        end
                        else
                        begin
                            sh_next    = count_reg;
                            state_next = (count_reg > at_reg) ? S_INS_RD : S_INS_WR;
                        end
                    end
                    dmts_pkg::OP_REMOVE:
                    begin
                        if (!found_reg)
                        begin
                            st_next = dmts_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            rem_pos_next = fpos_reg;
                            sh_next      = fpos_reg;
                            state_next   = S_REM_RD;
                        end
                    end
                    dmts_pkg::OP_RELEASE:
                    begin
                        if (!found_reg)
                        begin
                            st_next = dmts_pkg::ST_NOT_FOUND;
                        end
                        else if (!(run_valid_reg && run_slot_reg == fpos_reg[IW-1:0]))
                        begin
                            ph_we          = 1'b1;
                            ph_waddr       = fpos_reg[IW-1:0];
                            ph_wdata       = dmts_pkg::PH_READY;
                            scan_disp_next = 1'b1;
                            idx_next       = '0;
                            best_v_next    = 1'b0;
                            state_next     = S_SCAN_RD;
                        end
                    end
                    dmts_pkg::OP_YIELD:
                    begin
                        if (!found_reg)
                        begin
                            st_next = dmts_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            ph_we    = 1'b1;
                            ph_waddr = fpos_reg[IW-1:0];
                            ph_wdata = dmts_pkg::PH_SLEEP;
                            if (run_valid_reg && run_slot_reg == fpos_reg[IW-1:0])
                            begin
                                run_valid_next = 1'b0;
                                run_slot_next  = '0;
                                run_id_next    = '0;
                            end
                        end
                        // dispatch even for an unknown id
                        scan_disp_next = 1'b1;
                        idx_next       = '0;
                        best_v_next    = 1'b0;
                        state_next     = S_SCAN_RD;
                    end
                    default:
                    begin
                        st_next = dmts_pkg::ST_INVALID;
                    end
                endcase
            end
            S_INS_RD:
            begin
                state_next = S_INS_MV;
            end
            S_INS_MV:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = sh_reg[IW-1:0];
                tbl_wdata  = tbl_q;
                ph_we      = 1'b1;
                ph_waddr   = sh_reg[IW-1:0];
                ph_wdata   = ph_q;
                sh_next    = sh_dn;
                state_next = (sh_dn > at_reg) ? S_INS_RD : S_INS_WR;
            end
            S_INS_WR:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = at_reg[IW-1:0];
                tbl_wdata  = {rid_reg, rper_reg, rdl_reg, rcost_reg};
                ph_we      = 1'b1;
                ph_waddr   = at_reg[IW-1:0];
                ph_wdata   = dmts_pkg::PH_SLEEP;
                count_next = count_reg + CW'(1);
                if (run_valid_reg && CW'(run_slot_reg) >= at_reg)
                begin
                    run_slot_next = run_slot_reg + IW'(1);
                end
                i_next     = '0;
                base_next  = '0;
                state_next = S_RTA_I;
            end
            S_REM_RD:
            begin
                if (sh_up < count_reg)
                begin
                    state_next = S_REM_MV;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    if (run_valid_reg && CW'(run_slot_reg) == rem_pos_reg)
                    begin
                        run_valid_next = 1'b0;
                        run_slot_next  = '0;
                        run_id_next    = '0;
                    end
                    else if (run_valid_reg && CW'(run_slot_reg) > rem_pos_reg)
                    begin
                        run_slot_next = run_slot_reg - IW'(1);
                    end
                    state_next = S_OUT;
                end
            end
            S_REM_MV:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = sh_reg[IW-1:0];
                tbl_wdata  = tbl_q;
                ph_we      = 1'b1;
                ph_waddr   = sh_reg[IW-1:0];
                ph_wdata   = ph_q;
                sh_next    = sh_up;
                state_next = S_REM_RD;
            end
            S_RTA_I:
            begin
                state_next = (i_reg == count_reg) ? S_OUT : S_RTA_I2;
            end
            S_RTA_I2:
            begin
                c_next     = q_cost;
                d_next     = q_dl;
                // start from the saturated sum of all earlier costs and its own cost
                t_next     = (sum_bq > TSAT2) ? TSAT : sum_bq[TW:0];
                state_next = S_RTA_IT;
            end
            S_RTA_IT:
            begin
                inter_next = '0;
                j_next     = '0;
                state_next = S_RTA_J;
            end
            S_RTA_J:
            begin
                state_next = (j_reg == i_reg) ? S_RTA_CHK : S_RTA_J2;
            end
            S_RTA_J2:
            begin
                mdu_start  = 1'b1;
                state_next = S_RTA_MW;
            end
            S_RTA_MW:
            begin
                if (mdu_done)
                begin
                    inter_next = (sum_ir > TSAT2) ? TSAT : sum_ir[TW:0];
                    j_next     = j_reg + CW'(1);
                    state_next = S_RTA_J;
                end
            end
            S_RTA_CHK:
            begin
                if (sum_ic <= {1'b0, t_reg})
                begin
                    if (t_reg > {1'b0, d_reg})
                    begin
                        st_next      = dmts_pkg::ST_UNSCHED;
                        rem_pos_next = at_reg;
                        sh_next      = at_reg;
                        state_next   = S_REM_RD;
                    end
                    else
                    begin
                        base_next  = (sum_bc > TSAT2) ? TSAT : sum_bc[TW:0];
                        i_next     = i_reg + CW'(1);
                        state_next = S_RTA_I;
                    end
                end
                else if (sum_ic > {2'b00, d_reg})
                begin
                    st_next      = dmts_pkg::ST_UNSCHED;
                    rem_pos_next = at_reg;
                    sh_next      = at_reg;
                    state_next   = S_REM_RD;
                end
                else
                begin
                    t_next     = sum_ic[TW:0];
                    state_next = S_RTA_IT;
                end
            end
            S_DISP:
            begin
                if (!best_v_reg || (run_valid_reg && run_dl_reg < best_dl_reg))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    if (run_valid_reg)
                    begin
                        ph_we    = 1'b1;
                        ph_waddr = run_slot_reg;
                        ph_wdata = dmts_pkg::PH_READY;
                        pv_next  = 1'b1;
                        pid_next = run_id_reg;
                    end
                    state_next = S_DISP2;
                end
            end
            S_DISP2:
            begin
                ph_we          = 1'b1;
                ph_waddr       = best_reg;
                ph_wdata       = dmts_pkg::PH_RUN;
                run_valid_next = 1'b1;
                run_slot_next  = best_reg;
                run_id_next    = best_id_reg;
                run_dl_next    = best_dl_reg;
                sw_next        = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    o_st_next  = st_reg;
                    o_rv_next  = run_valid_reg;
                    o_rid_next = run_id_reg;
                    o_sw_next  = sw_reg;
                    o_pv_next  = pv_reg;
                    o_pid_next = pid_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            run_id_reg    <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            run_id_reg    <= run_id_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        rid_reg       <= rid_next;
        rper_reg      <= rper_next;
        rdl_reg       <= rdl_next;
        rcost_reg     <= rcost_next;
        run_dl_reg    <= run_dl_next;
        scan_disp_reg <= scan_disp_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        fpos_reg      <= fpos_next;
        at_set_reg    <= at_set_next;
        at_reg        <= at_next;
        best_v_reg    <= best_v_next;
        best_reg      <= best_next;
        best_dl_reg   <= best_dl_next;
        best_id_reg   <= best_id_next;
        sh_reg        <= sh_next;
        rem_pos_reg   <= rem_pos_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        base_reg      <= base_next;
        t_reg         <= t_next;
        inter_reg     <= inter_next;
        c_reg         <= c_next;
        d_reg         <= d_next;
        st_reg        <= st_next;
        sw_reg        <= sw_next;
        pv_reg        <= pv_next;
        pid_reg       <= pid_next;
        o_st_reg      <= o_st_next;
        o_rv_reg      <= o_rv_next;
        o_rid_reg     <= o_rid_next;
        o_sw_reg      <= o_sw_next;
        o_pv_reg      <= o_pv_next;
        o_pid_reg     <= o_pid_next;
    end

    // task table: id, period, deadline, cost
    dmts_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (raddr),
        .rdata (tbl_q)
    );

    // task phases, written alone on dispatch
    dmts_ram #(
        .WIDTH (PHW),
        .DEPTH (MAX_TASKS)
    ) u_ph_ram (
        .clk   (clk),
        .we    (ph_we),
        .waddr (ph_waddr),
        .wdata (ph_wdata),
        .raddr (raddr),
        .rdata (ph_q)
    );

    // interference term of one higher-priority task; period and cost read from the table
    dmts_mdu #(
        .TW (TW)
    ) u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mdu_start),
        .t     (t_reg),
        .p     (q_per),
        .c     (q_cost),
        .done  (mdu_done),
        .res   (mdu_res)
    );

    assign out_valid     = ov_reg;
    assign status        = o_st_reg;
    assign running_valid = o_rv_reg;
    assign running_id    = o_rid_reg;
    assign switched      = o_sw_reg;
    assign preempt_valid = o_pv_reg;
    assign preempt_id    = o_pid_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TASKS))
        else $error("task count above table depth");

    a_run_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (CW'(run_slot_reg) < count_reg))
        else $error("running slot outside table");

    a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !run_valid_reg |-> (run_id_reg == '0))
        else $error("running id kept with no running task");

    a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_sw_reg) |-> o_rv_reg)
        else $error("switch reported with nothing running");

endmodule

FILE: sim/tb_deadline_monotonic_task_scheduler_top.sv
`timescale 1ns / 100ps

module tb_deadline_monotonic_task_scheduler_top;

    localparam int NTASK = dmts_pkg::MAX_TASKS_DEF;
    localparam int TB_W  = dmts_pkg::TIME_BITS_DEF;
    localparam int IDW   = dmts_pkg::ID_W;
    localparam int PTW   = dmts_pkg::PORT_TIME_W;
    localparam logic [63:0] TSAT = 64'd1 << TB_W;

    typedef struct packed {
        logic [dmts_pkg::OP_W-1:0] op;
        logic [IDW-1:0]            id;
        logic [PTW-1:0]            per;
        logic [PTW-1:0]            dl;
        logic [PTW-1:0]            cost;
    } request_t;

    typedef struct packed {
        logic [dmts_pkg::ST_W-1:0] st;
        logic                      rv;
        logic [IDW-1:0]            rid;
        logic                      sw;
        logic                      pv;
        logic [IDW-1:0]            pid;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [dmts_pkg::OP_W-1:0] opcode;
    logic [IDW-1:0] task_id;
    logic [PTW-1:0] task_period;
    logic [PTW-1:0] task_deadline;
    logic [PTW-1:0] task_cost;
    logic out_valid;
    logic out_ready;
    logic [dmts_pkg::ST_W-1:0] status;
    logic running_valid;
    logic [IDW-1:0] running_id;
    logic switched;
    logic preempt_valid;
    logic [IDW-1:0] preempt_id;

    deadline_monotonic_task_scheduler_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .task_id(task_id), .task_period(task_period),
        .task_deadline(task_deadline), .task_cost(task_cost),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .running_valid(running_valid), .running_id(running_id),
        .switched(switched), .preempt_valid(preempt_valid), .preempt_id(preempt_id)
    );

    // shadow copy of the task table, kept sorted by deadline
    logic [IDW-1:0]              tbl_id    [NTASK];
    logic [PTW-1:0]              tbl_per   [NTASK];
    logic [PTW-1:0]              tbl_dl    [NTASK];
    logic [PTW-1:0]              tbl_cost  [NTASK];
    logic [dmts_pkg::PH_W-1:0]   tbl_phase [NTASK];
    int                          tbl_count;
    logic                        cur_run_v;
    int                          cur_run;

    request_t pending_reqs[$];
    verdict_t expected_verdicts[$];
    logic [IDW-1:0] known_ids[$];   // ids the stimulus likes to reuse
    int   mismatches;
    bit   hold_sender;
    bit   in_ready_seen;
    int   burst_left;
    int   gap_left;
    int   stall_phase;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [63:0] sat64(logic [63:0] x);
        return (x > TSAT) ? TSAT : x;
    endfunction

    function automatic int find_task(logic [IDW-1:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id)
                return i;
        return NTASK;
    endfunction

    task automatic drop_task(int pos);
        if (cur_run_v && cur_run == pos)
        begin
            cur_run_v = 1'b0;
            cur_run = 0;
        end
        else if (cur_run_v && cur_run > pos)
            cur_run--;
        for (int i = pos; i + 1 < tbl_count; i++)
        begin
            tbl_id[i] = tbl_id[i+1];
            tbl_per[i] = tbl_per[i+1];
            tbl_dl[i] = tbl_dl[i+1];
            tbl_cost[i] = tbl_cost[i+1];
            tbl_phase[i] = tbl_phase[i+1];
        end
        tbl_count--;
    endtask

    // iterative response-time test over the whole table, sums saturate
    function automatic bit table_feasible();
        logic [63:0] base, c, t, inter, p, n;
        bit fixed;
        base = 0;
        for (int i = 0; i < tbl_count; i++)
        begin
            c = 64'(tbl_cost[i]);
            t = sat64(base + c);
            fixed = 0;
            while (!fixed)
            begin
                inter = 0;
                for (int j = 0; j < i; j++)
                begin
                    p = 64'(tbl_per[j]);
                    n = (p == 0) ? TSAT : (t + p - 1) / p;
                    inter = sat64(inter + sat64(n * 64'(tbl_cost[j])));
                end
                if (inter + c <= t)
                    fixed = 1;
                else
                    t = inter + c;
                if (t > 64'(tbl_dl[i]))
                    return 0;
            end
            base = sat64(base + c);
        end
        return 1;
    endfunction

    task automatic pick_next(inout verdict_t v);
        int best;
        best = NTASK;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_phase[i] == dmts_pkg::PH_READY
                && (best == NTASK || tbl_dl[i] <= tbl_dl[best]))
                best = i;
        if (best == NTASK)
            return;
        if (cur_run_v && tbl_dl[cur_run] < tbl_dl[best])
            return;
        if (cur_run_v)
        begin
            tbl_phase[cur_run] = dmts_pkg::PH_READY;
            v.pv = 1'b1;
            v.pid = tbl_id[cur_run];
        end
        tbl_phase[best] = dmts_pkg::PH_RUN;
        cur_run_v = 1'b1;
        cur_run = best;
        v.sw = 1'b1;
    endtask

    task automatic predict_request(request_t r);
        verdict_t v;
        int pos, at;
        v = '0;
        pos = find_task(r.id);
        case (r.op)
            dmts_pkg::OP_REG_DM, dmts_pkg::OP_REG_RM:
            begin
                if ((r.op == dmts_pkg::OP_REG_RM && r.per != r.dl) || r.per == 0)
                    v.st = dmts_pkg::ST_INVALID;
                else if (pos != NTASK)
                    v.st = dmts_pkg::ST_DUP;
                else if (tbl_count >= NTASK)
                    v.st = dmts_pkg::ST_FULL;
                else
                begin
                    at = 0;
                    while (at < tbl_count && tbl_dl[at] < r.dl)
                        at++;
                    for (int i = tbl_count; i > at; i--)
                    begin
                        tbl_id[i] = tbl_id[i-1];
                        tbl_per[i] = tbl_per[i-1];
                        tbl_dl[i] = tbl_dl[i-1];
                        tbl_cost[i] = tbl_cost[i-1];
                        tbl_phase[i] = tbl_phase[i-1];
                    end
                    tbl_id[at] = r.id;
                    tbl_per[at] = r.per;
                    tbl_dl[at] = r.dl;
                    tbl_cost[at] = r.cost;
                    tbl_phase[at] = dmts_pkg::PH_SLEEP;
                    tbl_count++;
                    if (cur_run_v && cur_run >= at)
                        cur_run++;
                    if (!table_feasible())
                    begin
                        drop_task(at);
                        v.st = dmts_pkg::ST_UNSCHED;
                    end
                end
            end
            dmts_pkg::OP_REMOVE:
            begin
                if (pos == NTASK)
                    v.st = dmts_pkg::ST_NOT_FOUND;
                else
                    drop_task(pos);
            end
            dmts_pkg::OP_RELEASE:
            begin
                if (pos == NTASK)
                    v.st = dmts_pkg::ST_NOT_FOUND;
                else if (!(cur_run_v && cur_run == pos))
                begin
                    tbl_phase[pos] = dmts_pkg::PH_READY;
                    pick_next(v);
                end
            end
            dmts_pkg::OP_YIELD:
            begin
                if (pos == NTASK)
                    v.st = dmts_pkg::ST_NOT_FOUND;
                else
                begin
                    tbl_phase[pos] = dmts_pkg::PH_SLEEP;
                    if (cur_run_v && cur_run == pos)
                    begin
                        cur_run_v = 1'b0;
                        cur_run = 0;
                    end
                end
                pick_next(v);
            end
            default:
                v.st = dmts_pkg::ST_INVALID;
        endcase
        v.rv = cur_run_v;
        v.rid = cur_run_v ? tbl_id[cur_run] : '0;
        expected_verdicts.push_back(v);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_req(logic [dmts_pkg::OP_W-1:0] op, logic [IDW-1:0] id,
                             logic [15:0] per, logic [15:0] dl, logic [15:0] cost);
        request_t r;
        r.op = op;
        r.id = id;
        r.per = per;
        r.dl = dl;
        r.cost = cost;
        pending_reqs.push_back(r);
    endtask

    // pick an id: mostly from a small reused pool so that hits are common
    function automatic logic [IDW-1:0] some_id();
        if (known_ids.size() > 0 && $urandom_range(0, 9) < 8)
            return known_ids[$urandom_range(0, known_ids.size() - 1)];
        return IDW'($urandom_range(0, 22'h3FFFFF));
    endfunction

    // driver: bursts of beats separated by random gaps
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            // a beat accepted at the last rising edge is consumed here
            if (in_valid && in_ready_seen)
                pending_reqs.pop_front();
            if (in_valid && !in_ready_seen)
                ; // hold payload until accepted
            else if (hold_sender && expected_verdicts.size() != 0)
                in_valid <= 1'b0;
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                burst_left--;
                in_valid <= 1'b1;
                opcode <= pending_reqs[0].op;
                task_id <= pending_reqs[0].id;
                task_period <= pending_reqs[0].per;
                task_deadline <= pending_reqs[0].dl;
                task_cost <= pending_reqs[0].cost;
            end
        end
    end

    // handshake sampled at the rising edge; prediction happens on acceptance
    always @(posedge clk)
    begin
        in_ready_seen = 1'b0;
        if (rst_n && in_valid && in_ready)
        begin
            in_ready_seen = 1'b1;
            predict_request(pending_reqs[0]);
        end
    end

    // receiver stall pattern: periods of steady ready and periods of random stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_phase = 0;
        end
        else
        begin
            stall_phase = (stall_phase + 1) % 96;
            if (stall_phase < 32)
                out_ready <= 1'b1;
            else if (stall_phase < 64)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= ($urandom_range(0, 1) == 0);
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        verdict_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch("unexpected result beat", 32'd1, 32'd0);
            end
            else
            begin
                w = expected_verdicts.pop_front();
                if (status !== w.st)
                    report_mismatch("status", 32'(status), 32'(w.st));
                if (running_valid !== w.rv)
                    report_mismatch("running_valid", 32'(running_valid), 32'(w.rv));
                if (running_id !== w.rid)
                    report_mismatch("running_id", 32'(running_id), 32'(w.rid));
                if (switched !== w.sw)
                    report_mismatch("switched", 32'(switched), 32'(w.sw));
                if (preempt_valid !== w.pv)
                    report_mismatch("preempt_valid", 32'(preempt_valid), 32'(w.pv));
                if (preempt_id !== w.pid)
                    report_mismatch("preempt_id", 32'(preempt_id), 32'(w.pid));
            end
        end
    end

    initial
    begin
        logic [IDW-1:0] nid;
        logic [15:0] p, d;
        int roll;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = '0;
        task_id = '0;
        task_period = '0;
        task_deadline = '0;
        task_cost = '0;
        mismatches = 0;
        hold_sender = 0;
        tbl_count = 0;
        cur_run_v = 0;
        cur_run = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: unknown ids, bad parameters, extremes, preemption, removal of runner
        queue_req(dmts_pkg::OP_REMOVE, 22'd5, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_RELEASE, 22'h3FFFFF, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_YIELD, 22'd0, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_REG_DM, 22'd1, 16'd0, 16'd10, 16'd1);
        queue_req(dmts_pkg::OP_REG_RM, 22'd1, 16'd10, 16'd11, 16'd1);
        queue_req(3'd5, 22'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(3'd7, 22'h2AAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        queue_req(dmts_pkg::OP_REG_DM, 22'd1, 16'd100, 16'd100, 16'd10);
        queue_req(dmts_pkg::OP_REG_DM, 22'd1, 16'd100, 16'd100, 16'd10);
        queue_req(dmts_pkg::OP_REG_RM, 22'h3FFFFF, 16'hFFFF, 16'hFFFF, 16'd5);
        queue_req(dmts_pkg::OP_REG_DM, 22'd2, 16'd50, 16'd40, 16'd5);
        queue_req(dmts_pkg::OP_REG_DM, 22'd3, 16'd1, 16'd1, 16'hFFFF);
        queue_req(dmts_pkg::OP_REG_DM, 22'd4, 16'd1, 16'hFFFF, 16'd1);
        queue_req(dmts_pkg::OP_RELEASE, 22'h3FFFFF, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_RELEASE, 22'd1, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_RELEASE, 22'd1, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_RELEASE, 22'd2, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_YIELD, 22'h3FFFFF, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_YIELD, 22'd2, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_REMOVE, 22'd1, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_YIELD, 22'd77, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_REMOVE, 22'h3FFFFF, 16'd0, 16'd0, 16'd0);
        queue_req(dmts_pkg::OP_REMOVE, 22'd2, 16'd0, 16'd0, 16'd0);

        // wait for the directed part to drain before the random mix
        wait (pending_reqs.size() == 0);
        hold_sender = 1;
        wait (expected_verdicts.size() == 0);
        hold_sender = 0;

        // random: mostly feasible tasks from a reused id pool, so the table fills up
        for (int k = 0; k < 8; k++)
            known_ids.push_back(IDW'($urandom_range(0, 22'h3FFFFF)));
        for (int k = 0; k < 24; k++)
            known_ids.push_back(IDW'($urandom_range(1, 40)));
        for (int k = 0; k < 118; k++)
        begin
            roll = $urandom_range(0, 99);
            nid = some_id();
            if (roll < 40)
            begin
                p = 16'($urandom_range(1, 16'hFFFF));
                if ($urandom_range(0, 3) == 0)
                    p = 16'($urandom_range(1, 400));
                d = ($urandom_range(0, 1) == 0) ? p : 16'($urandom_range(1, 16'hFFFF));
                if ($urandom_range(0, 9) == 0)
                    p = 16'd0;
                queue_req($urandom_range(0, 1) ? dmts_pkg::OP_REG_RM : dmts_pkg::OP_REG_DM,
                          nid, p, d,
                          ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                      : 16'($urandom_range(0, 20)));
            end
            else if (roll < 65)
                queue_req(dmts_pkg::OP_RELEASE, nid, 16'($urandom), 16'($urandom),
                          16'($urandom));
            else if (roll < 85)
                queue_req(dmts_pkg::OP_YIELD, nid, 16'($urandom), 16'($urandom),
                          16'($urandom));
            else if (roll < 97)
                queue_req(dmts_pkg::OP_REMOVE, nid, 16'($urandom), 16'($urandom),
                          16'($urandom));
            else
                queue_req(3'($urandom_range(5, 7)), nid, 16'($urandom), 16'($urandom),
                          16'($urandom));
        end
        wait (pending_reqs.size() == 0);
        wait (expected_verdicts.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // a register may need several passes of the analysis over a full table;
    // 141 requests fit well inside this budget
    initial
    begin
        #200000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
